[rtl/bglu_pkg.sv]
// ----------------------------------------------------------------------------
// bglu_pkg
// Shared types and constants for the binary gcd / lcm unit.
// ----------------------------------------------------------------------------
package bglu_pkg;

  localparam int unsigned OPERAND_WIDTH_DEF = 32;

  // operation select
  localparam logic CMD_GCD = 1'b0;
  localparam logic CMD_LCM = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_ZERO = 2'd2
  } status_e;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_START   = 9'b000000010,
    S_STRIP   = 9'b000000100,
    S_XEVEN   = 9'b000001000,
    S_RED     = 9'b000010000,
    S_RESTORE = 9'b000100000,
    S_DIV     = 9'b001000000,
    S_MUL     = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_e;

endpackage

[rtl/bglu_addsub.sv]
// ----------------------------------------------------------------------------
// bglu_addsub
// Shared adder/subtractor; result carries one guard bit (carry or sign).
// ----------------------------------------------------------------------------
module bglu_addsub #(
  parameter int unsigned W = 32
) (
  input  logic [W:0]   opa_i,
  input  logic [W:0]   opb_i,
  input  logic         sub_i,
  output logic [W+1:0] sum_o
);

  logic [W+1:0] opb_ext;

  // two's complement of the operand on subtract; top bit of sum is the sign
  assign opb_ext = sub_i ? ~{1'b0, opb_i} : {1'b0, opb_i};
  assign sum_o   = {1'b0, opa_i} + opb_ext + {{(W+1){1'b0}}, sub_i};

endmodule

[rtl/binary_gcd_lcm_unit_top.sv]
// ----------------------------------------------------------------------------
// binary_gcd_lcm_unit_top
// Iterative Stein gcd and lcm unit built around one shared add/subtract unit.
// ----------------------------------------------------------------------------
// One word in, one word out. cmd_i selects gcd or lcm of the unsigned operands
// a_i and b_i. The unit works on one word at a time and deasserts in_ready_o
// until its result has moved into the output register; that register lets the
// next word in while a result still waits for out_ready_i. Timing depends on
// the operands, with one step per cycle of the shared adder/subtractor:
// capture and zero check, stripping common and then the remaining factors of
// two of a, the shift/compare/subtract reduction (an out-of-order pair costs
// one extra swap step), and restoring the common power of two. lcm then adds
// a restoring division of a by the gcd and a shift-add multiply by b.
// status_o reports an lcm whose product exceeds W bits (low W bits are
// returned) and lcm(0,0), which returns 0 without dividing. gcd with one
// zero operand returns the other; gcd status is always ok.
// ----------------------------------------------------------------------------
module binary_gcd_lcm_unit_top #(
  parameter int unsigned OPERAND_WIDTH = bglu_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     cmd_i,
  input  logic [OPERAND_WIDTH-1:0] a_i,
  input  logic [OPERAND_WIDTH-1:0] b_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [OPERAND_WIDTH-1:0] result_o,
  output bglu_pkg::status_e        status_o
);

  import bglu_pkg::*;

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned KW = $clog2(W);

  // control
  state_e         state_q, state_d;
  logic [KW-1:0]  k_q, k_d;        // common power of two
  logic [KW-1:0]  cnt_q, cnt_d;    // division / multiply step
  logic           zz_q, zz_d;      // lcm of two zeros
  logic           out_valid_q, out_valid_d;

  // working data
  logic [W-1:0]   x_q, x_d;        // gcd operand, then divisor
  logic [W-1:0]   y_q, y_d;        // gcd operand, dividend/quotient, multiplier/low product
  logic [W-1:0]   r_q, r_d;        // division remainder
  logic [W-1:0]   hi_q, hi_d;      // high half of product
  logic [W-1:0]   a_q, a_d;
  logic [W-1:0]   b_q, b_d;
  logic           cmd_q, cmd_d;
  logic [W-1:0]   result_q, result_d;
  status_e        status_q, status_d;

  // shared arithmetic unit
  logic [W:0]     alu_opa, alu_opb;
  logic           alu_sub;
  logic [W+1:0]   alu_sum;
  logic           alu_neg;

  logic [W:0]     rsh;             // remainder shifted with next dividend bit
  logic [W:0]     psum;            // partial product after optional add

  bglu_addsub #(
    .W (W)
  ) u_addsub (
    .opa_i (alu_opa),
    .opb_i (alu_opb),
    .sub_i (alu_sub),
    .sum_o (alu_sum)
  );

  assign alu_neg = alu_sum[W+1];
  assign rsh     = {r_q, y_q[W-1]};
  assign psum    = y_q[0] ? alu_sum[W:0] : {1'b0, hi_q};

  // operand steering: gcd compares y - x, division trials rsh - x,
  // multiply adds b into the high half
  always_comb begin
    alu_opa = {1'b0, y_q};
    alu_opb = {1'b0, x_q};
    alu_sub = 1'b1;
    case (state_q)
      S_DIV: begin
        alu_opa = rsh;
      end
      S_MUL: begin
        alu_opa = {1'b0, hi_q};
        alu_opb = {1'b0, b_q};
        alu_sub = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    zz_d        = zz_q;
    x_d         = x_q;
    y_d         = y_q;
    r_d         = r_q;
    hi_d        = hi_q;
    a_d         = a_q;
    b_d         = b_q;
    cmd_d       = cmd_q;
    result_d    = result_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          x_d     = a_i;
          y_d     = b_i;
          a_d     = a_i;
          b_d     = b_i;
          cmd_d   = cmd_i;
          zz_d    = 1'b0;
          k_d     = '0;
          state_d = S_START;
        end
      end

      S_START: begin
        if (cmd_q == CMD_LCM && x_q == '0 && y_q == '0) begin
          zz_d    = 1'b1;
          y_d     = '0;
          state_d = S_DONE;
        end else if (x_q == '0 || y_q == '0) begin
          // gcd is the other operand
          if (x_q == '0) begin
            x_d = y_q;
          end
          if (cmd_q == CMD_LCM) begin
            r_d     = '0;
            y_d     = a_q;
            cnt_d   = '0;
            state_d = S_DIV;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          state_d = S_STRIP;
        end
      end

      S_STRIP: begin
        if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + 1'b1;
        end else begin
          state_d = S_XEVEN;
        end
      end

      S_XEVEN: begin
        if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else begin
          state_d = S_RED;
        end
      end

      S_RED: begin
        if (y_q == '0) begin
          state_d = S_RESTORE;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (alu_neg) begin
          // x > y: swap, subtract next cycle
          x_d = y_q;
          y_d = x_q;
        end else begin
          y_d = alu_sum[W-1:0];
        end
      end

      S_RESTORE: begin
        if (k_q == '0) begin
          if (cmd_q == CMD_LCM) begin
            r_d     = '0;
            y_d     = a_q;
            cnt_d   = '0;
            state_d = S_DIV;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          x_d = x_q << 1;
          k_d = k_q - 1'b1;
        end
      end

      S_DIV: begin
        // restoring division a / gcd, quotient shifts into y
        y_d = {y_q[W-2:0], ~alu_neg};
        r_d = alu_neg ? rsh[W-1:0] : alu_sum[W-1:0];
        if (cnt_q == KW'(W-1)) begin
          cnt_d   = '0;
          hi_d    = '0;
          state_d = S_MUL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_MUL: begin
        // shift-add quotient * b, low half ends in y
        hi_d = psum[W:1];
        y_d  = {psum[0], y_q[W-1:1]};
        if (cnt_q == KW'(W-1)) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (cmd_q == CMD_LCM) begin
            result_d = y_q;
            if (zz_q) begin
              status_d = ST_ZERO;
            end else if (hi_q != '0) begin
              status_d = ST_OVF;
            end else begin
              status_d = ST_OK;
            end
          end else begin
            result_d = x_q;
            status_d = ST_OK;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      cnt_q       <= '0;
      zz_q        <= 1'b0;
      out_valid_q <= 1'b0;
      cmd_q       <= CMD_GCD;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      cnt_q       <= cnt_d;
      zz_q        <= zz_d;
      out_valid_q <= out_valid_d;
      cmd_q       <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    r_q      <= r_d;
    hi_q     <= hi_d;
    a_q      <= a_d;
    b_q      <= b_d;
    result_q <= result_d;
    status_q <= status_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign status_o    = status_q;

endmodule
